>>> hdl/iarc_pkg.sv
// Package for the IPv4 address rewrite and header checksum block.
// Holds controller states, status codes, the command and status bundles and helper functions.
// No dependencies.
package iarc_pkg;

  localparam int SUM_W = 21;
  localparam int IDX_W = 6;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] MIN_IHL    = 4'd5;

  localparam logic [IDX_W-1:0] OFS_CSUM_HI = 6'd10;
  localparam logic [IDX_W-1:0] OFS_CSUM_LO = 6'd11;
  localparam logic [IDX_W-1:0] OFS_SRC_0   = 6'd12;
  localparam logic [IDX_W-1:0] OFS_SRC_1   = 6'd13;
  localparam logic [IDX_W-1:0] OFS_SRC_2   = 6'd14;
  localparam logic [IDX_W-1:0] OFS_SRC_3   = 6'd15;
  localparam logic [IDX_W-1:0] OFS_DST_0   = 6'd16;
  localparam logic [IDX_W-1:0] OFS_DST_1   = 6'd17;
  localparam logic [IDX_W-1:0] OFS_DST_2   = 6'd18;
  localparam logic [IDX_W-1:0] OFS_DST_3   = 6'd19;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOT_V4  = 2'd1;
  localparam logic [1:0] STAT_SHORT   = 2'd2;
  localparam logic [1:0] STAT_BAD_IHL = 2'd3;

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_HEADER,
    ST_PAYLOAD,
    ST_REJECT,
    ST_BURST_RD,
    ST_BURST_OUT
  } state_t;

  typedef struct packed {
    logic first;
    logic hdr;
    logic pay;
    logic rej;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic first_bad;
    logic hdr_done;
    logic burst_end;
    logic burst_ok;
    logic blast;
    logic out_free;
  } sts_t;

  // Header byte with new addresses in place and checksum bytes cleared.
  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                          input logic [7:0] b,
                                          input logic [31:0] src,
                                          input logic [31:0] dst);
    logic [7:0] r;
    r = b;
    case (idx)
      OFS_CSUM_HI: r = 8'h00;
      OFS_CSUM_LO: r = 8'h00;
      OFS_SRC_0:   r = src[31:24];
      OFS_SRC_1:   r = src[23:16];
      OFS_SRC_2:   r = src[15:8];
      OFS_SRC_3:   r = src[7:0];
      OFS_DST_0:   r = dst[31:24];
      OFS_DST_1:   r = dst[23:16];
      OFS_DST_2:   r = dst[15:8];
      OFS_DST_3:   r = dst[7:0];
      default:     r = b;
    endcase
    return r;
  endfunction

  // End-around carry fold and complement.
  function automatic logic [15:0] fold_csum(input logic [SUM_W-1:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[15:0]} + {12'd0, s[SUM_W-1:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

>>> hdl/iarc_ctrl.sv
// Controller state machine for the IPv4 address rewrite block.
// Drives input stall and datapath commands from datapath status; uses iarc_pkg.
module iarc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  iarc_pkg::sts_t  sts,
  output iarc_pkg::cmd_t  cmd,
  output iarc_pkg::state_t state
);
  import iarc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FIRST;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_FIRST: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.first = 1'b1;
          if (sts.in_last) begin
            state_nxt = ST_FIRST;
          end else if (sts.first_bad) begin
            state_nxt = ST_REJECT;
          end else begin
            state_nxt = ST_HEADER;
          end
        end
      end
      ST_HEADER: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.hdr = 1'b1;
          if (sts.hdr_done || sts.in_last) begin
            state_nxt = ST_BURST_RD;
          end
        end
      end
      ST_PAYLOAD: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.pay = 1'b1;
          if (sts.in_last) begin
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_REJECT: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.rej = 1'b1;
          if (sts.in_last) begin
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_BURST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_BURST_OUT;
      end
      ST_BURST_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.burst_end) begin
            state_nxt = ST_BURST_RD;
          end else if (sts.burst_ok && !sts.blast) begin
            state_nxt = ST_PAYLOAD;
          end else begin
            state_nxt = ST_FIRST;
          end
        end
      end
      default: begin
        state_nxt = ST_FIRST;
      end
    endcase
  end

  assign state = state_r;

endmodule

>>> hdl/iarc_dp.sv
// Datapath for the IPv4 address rewrite block: header buffer, counters,
// checksum accumulator, address registers and output register. Uses iarc_pkg.
module iarc_dp #(
  parameter int MAX_HEADER_BYTES = 60
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_data_byte,
  input  logic           in_last_byte,
  input  logic [31:0]    in_new_source_addr,
  input  logic [31:0]    in_new_dest_addr,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic [1:0]     out_status,
  input  iarc_pkg::cmd_t cmd,
  output iarc_pkg::sts_t sts
);
  import iarc_pkg::*;

  localparam int LEN_W = $clog2(MAX_HEADER_BYTES + 1);
  localparam int AW    = $clog2(MAX_HEADER_BYTES);

  logic [7:0]       hdr_mem_r [MAX_HEADER_BYTES];
  logic [7:0]       rd_data_r;

  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] hlen_r, hlen_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0] blen_r, blen_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [1:0]       rej_r, rej_nxt;
  logic             burst_ok_r, burst_ok_nxt;
  logic             blast_r, blast_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             first_bad;
  logic [1:0]       first_code;
  logic [5:0]       ihl4;
  logic [LEN_W-1:0] hlen_first;
  logic [LEN_W-1:0] cnt_inc;
  logic             hdr_done;
  logic [7:0]       acc_byte;
  logic [15:0]      acc_word;
  logic [15:0]      csum;
  logic [IDX_W-1:0] rd_pos;
  logic [7:0]       emit_byte;
  logic [LEN_W-1:0] rd_inc;
  logic             burst_end;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  assign first_bad  = (in_data_byte[7:4] != IP_VERSION) || (in_data_byte[3:0] < MIN_IHL);
  assign first_code = (in_data_byte[7:4] != IP_VERSION) ? STAT_NOT_V4 : STAT_BAD_IHL;
  assign ihl4       = {in_data_byte[3:0], 2'b00};
  assign hlen_first = (ihl4 > 6'(MAX_HEADER_BYTES)) ? LEN_W'(MAX_HEADER_BYTES)
                                                     : LEN_W'(ihl4);

  assign cnt_inc  = cnt_r + 1'b1;
  assign hdr_done = (cnt_inc >= hlen_r);
  assign acc_byte = hdr_byte(IDX_W'(cnt_r), in_data_byte, src_r, dst_r);
  assign acc_word = cnt_r[0] ? {8'h00, acc_byte} : {acc_byte, 8'h00};

  assign csum   = fold_csum(sum_r);
  assign rd_pos = IDX_W'(rd_idx_r);
  assign rd_inc = rd_idx_r + 1'b1;
  assign burst_end = (rd_inc == blen_r);

  always_comb begin
    if (!burst_ok_r) begin
      emit_byte = rd_data_r;
    end else if (rd_pos == OFS_CSUM_HI) begin
      emit_byte = csum[15:8];
    end else if (rd_pos == OFS_CSUM_LO) begin
      emit_byte = csum[7:0];
    end else begin
      emit_byte = hdr_byte(rd_pos, rd_data_r, src_r, dst_r);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign wr_en    = cmd.first || cmd.hdr;
  assign wr_addr  = cmd.first ? '0 : cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem_r[wr_addr] <= in_data_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= hdr_mem_r[rd_idx_r[AW-1:0]];
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    hlen_nxt       = hlen_r;
    rd_idx_nxt     = rd_idx_r;
    blen_nxt       = blen_r;
    sum_nxt        = sum_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rej_nxt        = rej_r;
    burst_ok_nxt   = burst_ok_r;
    blast_nxt      = blast_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.first) begin
      src_nxt  = in_new_source_addr;
      dst_nxt  = in_new_dest_addr;
      cnt_nxt  = LEN_W'(1);
      sum_nxt  = SUM_W'({in_data_byte, 8'h00});
      rej_nxt  = first_code;
      hlen_nxt = hlen_first;
      if (first_bad || in_last_byte) begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = in_data_byte;
        out_last_nxt   = in_last_byte;
        out_status_nxt = first_bad ? first_code : STAT_SHORT;
      end
    end

    if (cmd.hdr) begin
      cnt_nxt      = cnt_inc;
      sum_nxt      = sum_r + SUM_W'(acc_word);
      rd_idx_nxt   = '0;
      burst_ok_nxt = hdr_done;
      blast_nxt    = hdr_done ? in_last_byte : 1'b1;
      blen_nxt     = hdr_done ? hlen_r : cnt_inc;
    end

    if (cmd.pay || cmd.rej) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = in_data_byte;
      out_last_nxt   = in_last_byte;
      out_status_nxt = cmd.rej ? rej_r : STAT_OK;
    end

    if (cmd.emit) begin
      rd_idx_nxt     = rd_inc;
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = emit_byte;
      out_last_nxt   = burst_end && blast_r;
      out_status_nxt = burst_ok_r ? STAT_OK : STAT_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    hlen_r       <= hlen_nxt;
    rd_idx_r     <= rd_idx_nxt;
    blen_r       <= blen_nxt;
    sum_r        <= sum_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    rej_r        <= rej_nxt;
    burst_ok_r   <= burst_ok_nxt;
    blast_r      <= blast_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign sts.in_last   = in_last_byte;
  assign sts.first_bad = first_bad;
  assign sts.hdr_done  = hdr_done;
  assign sts.burst_end = burst_end;
  assign sts.burst_ok  = burst_ok_r;
  assign sts.blast     = blast_r;
  assign sts.out_free  = out_free;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

>>> hdl/ipv4_address_rewrite_checksum_top.sv
// Top level of the IPv4 address rewrite and header checksum block.
// Joins iarc_ctrl and iarc_dp; uses iarc_pkg.
//
// Packets enter one byte per beat; the first beat also carries the new source and
// destination addresses. Header bytes (IHL*4, capped at MAX_HEADER_BYTES) are taken
// one per cycle into a buffer with no output while the checksum is summed on the fly.
// The header then leaves as a burst, each byte going through the registered read of
// the header buffer and then the output register load; input is held for the burst.
// Payload bytes and bytes of rejected packets pass through the output register at one
// per cycle while the output is not stalled. A bad version or an IHL below 5 passes
// the packet unchanged with an error status; a packet ending inside its header comes
// out unchanged with the short-packet status, as a burst unless it ends on byte one.
module ipv4_address_rewrite_checksum_top #(
  parameter int MAX_HEADER_BYTES = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_new_source_addr,
  input  logic [31:0] in_new_dest_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status
);
  import iarc_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  iarc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  iarc_dp #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_new_source_addr (in_new_source_addr),
    .in_new_dest_addr   (in_new_dest_addr),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_status         (out_status),
    .cmd                (cmd),
    .sts                (sts)
  );

  a_burst_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_BURST_RD || state == ST_BURST_OUT) |-> in_stall)
    else $error("input beat taken during header burst");

  a_payload_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && state == ST_PAYLOAD)
      |=> (out_valid && out_byte == $past(in_data_byte) && out_status == STAT_OK))
    else $error("payload beat not passed through");

  a_bad_first_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && state == ST_FIRST && sts.first_bad)
      |=> (out_valid && out_status != STAT_OK && out_status != STAT_SHORT))
    else $error("rejected first beat without error status");

endmodule

>>> bench/tb_ipv4_address_rewrite_checksum_top.sv
// Testbench for ipv4_address_rewrite_checksum_top: directed and random packets, predicted
// bytes checked in order against every output beat. Depends on iarc_pkg and the top level.
module tb_ipv4_address_rewrite_checksum_top;
  import iarc_pkg::*;

  localparam int HDR_MAX = 60;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_beat_t;

  typedef enum logic [1:0] {
    PM_IDLE,
    PM_HEADER,
    PM_PAYLOAD,
    PM_REJECT
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic [31:0] in_new_source_addr = 32'h0;
  logic [31:0] in_new_dest_addr = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_status;

  out_beat_t   pending_bytes[$];
  int          mismatches = 0;
  int          beats_seen = 0;
  int          random_sent = 0;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  rx_mode_t    pm = PM_IDLE;
  logic [7:0]  hdr_bytes[HDR_MAX];
  int unsigned hdr_cnt = 0;
  int unsigned hdr_len = 0;
  logic [31:0] src_q = 32'h0;
  logic [31:0] dst_q = 32'h0;

  ipv4_address_rewrite_checksum_top #(
    .MAX_HEADER_BYTES(HDR_MAX)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_new_source_addr (in_new_source_addr),
    .in_new_dest_addr   (in_new_dest_addr),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_status         (out_status)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] patched_byte(input int unsigned i);
    if (i == OFS_CSUM_HI || i == OFS_CSUM_LO) return 8'h00;
    if (i >= OFS_SRC_0 && i <= OFS_SRC_3) return 8'(src_q >> (8 * (OFS_SRC_3 - i)));
    if (i >= OFS_DST_0 && i <= OFS_DST_3) return 8'(dst_q >> (8 * (OFS_DST_3 - i)));
    return hdr_bytes[i];
  endfunction

  function automatic logic [1:0] reject_status();
    return (hdr_bytes[0][7:4] != IP_VERSION) ? STAT_NOT_V4 : STAT_BAD_IHL;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic l, input logic [1:0] st);
    out_beat_t e;
    e.data = b;
    e.last = l;
    e.status = st;
    pending_bytes.push_back(e);
  endtask

  task automatic push_rewritten_header(input logic l);
    int unsigned sum;
    logic [15:0] csum;
    logic [7:0]  b;
    sum = 0;
    for (int unsigned i = 0; i + 1 < hdr_len; i += 2) begin
      sum += {patched_byte(i), patched_byte(i + 1)};
    end
    if (hdr_len[0]) begin
      sum += {patched_byte(hdr_len - 1), 8'h00};
    end
    while (sum >> 16) begin
      sum = (sum & 32'hFFFF) + (sum >> 16);
    end
    csum = ~sum[15:0];
    for (int unsigned i = 0; i < hdr_len; i++) begin
      b = patched_byte(i);
      if (i == OFS_CSUM_HI) b = csum[15:8];
      if (i == OFS_CSUM_LO) b = csum[7:0];
      push_beat(b, (i + 1 == hdr_len) ? l : 1'b0, STAT_OK);
    end
  endtask

  task automatic predict_rewrite(input logic [7:0] b, input logic l,
                                 input logic [31:0] s, input logic [31:0] d);
    case (pm)
      PM_IDLE: begin
        src_q = s;
        dst_q = d;
        hdr_bytes[0] = b;
        hdr_cnt = 1;
        if (b[7:4] != IP_VERSION || b[3:0] < MIN_IHL) begin
          push_beat(b, l, reject_status());
          pm = l ? PM_IDLE : PM_REJECT;
        end else begin
          hdr_len = 4 * b[3:0];
          if (hdr_len > HDR_MAX) hdr_len = HDR_MAX;
          if (l) begin
            push_beat(b, 1'b1, STAT_SHORT);
          end else begin
            pm = PM_HEADER;
          end
        end
      end
      PM_HEADER: begin
        if (hdr_cnt < HDR_MAX) hdr_bytes[hdr_cnt] = b;
        hdr_cnt = (hdr_cnt + 1) & 63;
        if (hdr_cnt >= hdr_len) begin
          push_rewritten_header(l);
          pm = l ? PM_IDLE : PM_PAYLOAD;
        end else if (l) begin
          for (int unsigned i = 0; i < hdr_cnt && i < HDR_MAX; i++) begin
            push_beat(hdr_bytes[i], (i + 1 == hdr_cnt), STAT_SHORT);
          end
          pm = PM_IDLE;
        end
      end
      PM_PAYLOAD: begin
        push_beat(b, l, STAT_OK);
        if (l) pm = PM_IDLE;
      end
      default: begin
        push_beat(b, l, reject_status());
        if (l) pm = PM_IDLE;
      end
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic l,
                           input logic [31:0] s, input logic [31:0] d);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    in_new_source_addr <= s;
    in_new_dest_addr <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_rewrite(b, l, s, d);
  endtask

  task automatic send_packet(input byte_q_t pkt, input logic [31:0] s, input logic [31:0] d);
    for (int i = 0; i < pkt.size(); i++) begin
      send_beat(pkt[i], i == pkt.size() - 1, (i == 0) ? s : $urandom(),
                (i == 0) ? d : $urandom());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    q = {};
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic send_random_packet();
    byte_q_t pkt;
    int      kind;
    int      ihl;
    logic [3:0] ver;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 6);
      pkt = random_bytes(4 * ihl + $urandom_range(0, 12));
      pkt[0] = {IP_VERSION, 4'(ihl)};
    end else if (kind < 87) begin
      do ver = 4'($urandom_range(0, 15)); while (ver == IP_VERSION);
      pkt = random_bytes($urandom_range(1, 10));
      pkt[0][7:4] = ver;
    end else if (kind < 93) begin
      pkt = random_bytes($urandom_range(1, 10));
      pkt[0] = {IP_VERSION, 4'($urandom_range(0, 4))};
    end else begin
      ihl = $urandom_range(5, 15);
      pkt = random_bytes($urandom_range(1, 4 * ihl - 1));
      pkt[0] = {IP_VERSION, 4'(ihl)};
    end
    send_packet(pkt, $urandom(), $urandom());
    random_sent += pkt.size();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_req) begin
      hold_served <= hold_req;
      hold_left <= 250;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  always @(negedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %0d byte %h", beats_seen, out_byte));
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte !== e.data)
          report_mismatch($sformatf("beat %0d byte %h, want %h", beats_seen, out_byte, e.data));
        if (out_last !== e.last)
          report_mismatch($sformatf("beat %0d last %b, want %b", beats_seen, out_last, e.last));
        if (out_status !== e.status)
          report_mismatch($sformatf("beat %0d status %0d, want %0d", beats_seen, out_status,
                                    e.status));
      end
      beats_seen++;
    end
  end

  task automatic test_basic_rewrite();
    byte_q_t pkt;
    pkt = random_bytes(24);
    pkt[0] = 8'h45;
    send_packet(pkt, 32'hFFFF_FFFF, 32'h0000_0000);
    pkt = {};
    pkt.push_back(8'h45);
    repeat (19) pkt.push_back(8'hFF);
    repeat (2) pkt.push_back(8'h00);
    send_packet(pkt, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_longest_header();
    byte_q_t pkt;
    pkt = random_bytes(60);
    pkt[0] = 8'h4F;
    send_packet(pkt, $urandom(), $urandom());
  endtask

  task automatic test_wrong_version();
    byte_q_t pkt;
    pkt = random_bytes(3);
    pkt[0] = 8'h65;
    send_packet(pkt, $urandom(), $urandom());
    pkt = {8'hF5};
    send_packet(pkt, $urandom(), $urandom());
    pkt = random_bytes(2);
    pkt[0] = 8'h00;
    send_packet(pkt, $urandom(), $urandom());
  endtask

  task automatic test_short_ihl();
    byte_q_t pkt;
    pkt = random_bytes(4);
    pkt[0] = 8'h40;
    send_packet(pkt, $urandom(), $urandom());
    pkt = random_bytes(2);
    pkt[0] = 8'h44;
    send_packet(pkt, $urandom(), $urandom());
  endtask

  task automatic test_truncated_header();
    byte_q_t pkt;
    pkt = {8'h45};
    send_packet(pkt, $urandom(), $urandom());
    pkt = random_bytes(19);
    pkt[0] = 8'h45;
    send_packet(pkt, $urandom(), $urandom());
    pkt = random_bytes(30);
    pkt[0] = 8'h4F;
    send_packet(pkt, $urandom(), $urandom());
  endtask

  task automatic test_receiver_hold();
    byte_q_t pkt;
    hold_req++;
    repeat (3) begin
      pkt = random_bytes(30);
      pkt[0] = 8'h45;
      send_packet(pkt, $urandom(), $urandom());
    end
  endtask

  task automatic test_drain_pause();
    byte_q_t pkt;
    pkt = random_bytes(26);
    pkt[0] = 8'h46;
    send_packet(pkt, $urandom(), $urandom());
    wait_drained();
    pkt = random_bytes(21);
    pkt[0] = 8'h45;
    send_packet(pkt, $urandom(), $urandom());
  endtask

  task automatic test_random_traffic();
    calm = 1'b1;
    while (random_sent < 60) send_random_packet();
    calm = 1'b0;
    while (random_sent < 170) send_random_packet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_rewrite();
    test_longest_header();
    test_wrong_version();
    test_short_ihl();
    test_truncated_header();
    test_receiver_hold();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (30) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", pending_bytes.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
